// ===== sv/assert_macros.svh =====
// Assertion macros shared by the hit reconstruction RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define DHR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define DHR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dhr_pkg.sv =====
// Shared widths, register codes, exponential table and side-band type
// for the two-ended hit reconstruction pipeline. No dependencies.
package dhr_pkg;

	// Field widths
	localparam int T_W    = 20;
	localparam int E_W    = 18;
	localparam int H_W    = 13;
	localparam int ATT_W  = 16;
	localparam int CFG_W  = 16;
	localparam int DIST_W = H_W + 1;
	localparam int Z_W    = H_W + 1;
	localparam int ZL_W   = 16;
	localparam int ZT_W   = 17;
	localparam int CT_W   = 21;
	localparam int EC_W   = 24;
	localparam int SIG_W  = 16;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 96;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_FIBER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPEED   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_ATTEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_OFS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_COEFF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_FALLBACK = 3'd6;

	// Register reset values
	localparam logic [H_W-1:0]   RST_HALF_FIBER   = 13'd3120;
	localparam logic [H_W-1:0]   RST_HALF_SPEED   = 13'd2144;
	localparam logic [CFG_W-1:0] RST_TRANSIT      = 16'd372;
	localparam logic [CFG_W-1:0] RST_INV_ATTEN    = 16'd126;
	localparam logic [CFG_W-1:0] RST_TARGET_OFS   = 16'd2352;
	localparam logic [CFG_W-1:0] RST_RES_COEFF    = 16'd282;
	localparam logic [CFG_W-1:0] RST_RES_FALLBACK = 16'd480;

	// Attenuation argument: distance times reciprocal length, 20 fraction bits
	localparam int A_W    = DIST_W + ATT_W;
	localparam int FRAC_W = 20;
	localparam int N_W    = A_W - FRAC_W;

	// Exponential table, Q18 entries
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int KS_W = FRAC_W + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int EXP_W = 20;
	typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

	// Shift-and-subtract quotient, used only while building the table and E_ONE
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series of exp(num / depth) in Q32, rounded to Q18
	function automatic logic [63:0] exp_series_q18(input logic [63:0] num);
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 32;
		sum = term;
		for (int j = 1; j < 64; j++) begin
			if (term != 64'd0) begin
				term = udiv64(term * num, 64'(EXP_TABLE_DEPTH) * 64'(j));
				sum = sum + term;
			end
		end
		return (sum + (64'd1 << 13)) >> 14;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			tab[k] = EXP_W'(exp_series_q18(64'(k)));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();
	localparam logic [EXP_W-1:0] E_ONE = EXP_W'(exp_series_q18(64'(EXP_TABLE_DEPTH)));

	// Gain: Q18, held at 2^43. Eighteen multiplies by e reach the cap from 1.0.
	localparam int GAIN_W = 44;
	localparam logic [GAIN_W-1:0] GAIN_CAP = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam int GAIN_STEPS = 18;
	localparam int GAIN_LAT = GAIN_STEPS + 2;
	localparam int GAIN_SPLIT = GAIN_W / 2;

	// Resolution: 16 * coeff^2 / energy, then integer square root
	localparam int NUM_W = 2 * CFG_W + 4;
	localparam int DIV_LAT = NUM_W;
	localparam int ROOT_W = NUM_W / 2;
	localparam int SQRT_LAT = ROOT_W;

	// Pipeline bookkeeping
	localparam int ENERGY_LAT = 3;
	localparam int SIDE_LAT = GAIN_LAT + ENERGY_LAT + DIV_LAT + SQRT_LAT;
	localparam int EC_LAT = DIV_LAT + SQRT_LAT;
	localparam int PIPE_LAT = 3 + SIDE_LAT + 1;

	// Fields that ride alongside the long arithmetic
	typedef struct packed {
		logic signed [ZL_W-1:0] z_local;
		logic signed [ZT_W-1:0] z_target;
		logic signed [CT_W-1:0] cell_time;
		logic                   clamped;
		logic                   dual;
	} side_t;

endpackage

// ===== sv/dhr_gain.sv =====
// Attenuation gain exp(d * inv_atten): table lookup and repeated multiply by e.
// Depends on dhr_pkg.
module dhr_gain (
	input  logic                         clk,
	input  logic                         en,
	input  logic [dhr_pkg::DIST_W-1:0]   span,
	input  logic [dhr_pkg::ATT_W-1:0]    inv_atten,
	output logic [dhr_pkg::GAIN_W-1:0]   gain
);

	localparam int MP_W = dhr_pkg::GAIN_W - 1 + dhr_pkg::EXP_W;

	logic [dhr_pkg::A_W-1:0]    arg_s1;
	logic [dhr_pkg::KS_W-1:0]   kscaled;
	logic [dhr_pkg::EXP_IDX_W-1:0] kidx;
	logic [dhr_pkg::N_W-1:0]    n_sx [dhr_pkg::GAIN_STEPS];
	logic [dhr_pkg::GAIN_W-1:0] g_sx [dhr_pkg::GAIN_STEPS+1];
	logic [dhr_pkg::GAIN_W-1:0] g_nx [dhr_pkg::GAIN_STEPS];
	logic [MP_W-1:0]            prod [dhr_pkg::GAIN_STEPS];
	logic [MP_W-1:0]            rnd  [dhr_pkg::GAIN_STEPS];

	// Table index from the fraction bits
	assign kscaled = dhr_pkg::KS_W'(arg_s1[dhr_pkg::FRAC_W-1:0])
		* dhr_pkg::KS_W'(dhr_pkg::EXP_TABLE_DEPTH);
	assign kidx = kscaled[dhr_pkg::FRAC_W +: dhr_pkg::EXP_IDX_W];

	// One multiply by e per step, skipped past the integer part or the cap
	always_comb begin
		for (int i = 0; i < dhr_pkg::GAIN_STEPS; i++) begin
			prod[i] = MP_W'(g_sx[i][dhr_pkg::GAIN_W-2:0]) * MP_W'(dhr_pkg::E_ONE);
			rnd[i] = prod[i] + (MP_W'(1) << 17);
			if (n_sx[i] > dhr_pkg::N_W'(i) && g_sx[i] < dhr_pkg::GAIN_CAP) begin
				if (rnd[i][MP_W-1:18] > (MP_W-18)'(dhr_pkg::GAIN_CAP)) begin
					g_nx[i] = dhr_pkg::GAIN_CAP;
				end else begin
					g_nx[i] = rnd[i][18 +: dhr_pkg::GAIN_W];
				end
			end else begin
				g_nx[i] = g_sx[i];
			end
		end
	end

	// Argument, lookup, then the multiply chain
	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= dhr_pkg::A_W'(span) * dhr_pkg::A_W'(inv_atten);
			n_sx[0] <= arg_s1[dhr_pkg::A_W-1:dhr_pkg::FRAC_W];
			g_sx[0] <= dhr_pkg::GAIN_W'(dhr_pkg::EXP_TAB[kidx]);
			for (int i = 0; i < dhr_pkg::GAIN_STEPS; i++) begin
				g_sx[i+1] <= g_nx[i];
				if (i < dhr_pkg::GAIN_STEPS - 1) begin
					n_sx[i+1] <= n_sx[i];
				end
			end
		end
	end

	assign gain = g_sx[dhr_pkg::GAIN_STEPS];

endmodule

// ===== sv/dhr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dhr_pkg. Dividend is held static by the caller; divisor travels.
module dhr_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [dhr_pkg::NUM_W-1:0]   num,
	input  logic [dhr_pkg::EC_W-1:0]    den,
	output logic [dhr_pkg::NUM_W-1:0]   quo
);

	localparam int N = dhr_pkg::NUM_W;
	localparam int D = dhr_pkg::EC_W;

	logic [D-1:0]   rem_sx [N];
	logic [N-1:0]   quo_sx [N];
	logic [D-1:0]   den_sx [N];
	logic [D-1:0]   rin    [N];
	logic [N-1:0]   qin    [N];
	logic [D-1:0]   din    [N];
	logic [D:0]     trial  [N];
	logic [D-1:0]   rem_nx [N];
	logic [N-1:0]   quo_nx [N];

	// Shift in the next dividend bit, subtract when it fits
	always_comb begin
		rin[0] = '0;
		qin[0] = '0;
		din[0] = den;
		for (int j = 1; j < N; j++) begin
			rin[j] = rem_sx[j-1];
			qin[j] = quo_sx[j-1];
			din[j] = den_sx[j-1];
		end
		for (int j = 0; j < N; j++) begin
			trial[j] = {rin[j], num[N-1-j]};
			if (trial[j] >= {1'b0, din[j]}) begin
				rem_nx[j] = D'(trial[j] - {1'b0, din[j]});
				quo_nx[j] = {qin[j][N-2:0], 1'b1};
			end else begin
				rem_nx[j] = trial[j][D-1:0];
				quo_nx[j] = {qin[j][N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < N; j++) begin
				rem_sx[j] <= rem_nx[j];
				quo_sx[j] <= quo_nx[j];
				den_sx[j] <= din[j];
			end
		end
	end

	assign quo = quo_sx[N-1];

endmodule

// ===== sv/dhr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on dhr_pkg.
module dhr_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [dhr_pkg::NUM_W-1:0]    rad,
	output logic [dhr_pkg::ROOT_W-1:0]   root
);

	localparam int N  = dhr_pkg::NUM_W;
	localparam int R  = dhr_pkg::ROOT_W;
	localparam int RW = R + 2;

	logic [RW-1:0]  rem_sx  [R];
	logic [R-1:0]   root_sx [R];
	logic [N-1:0]   rad_sx  [R];
	logic [RW-1:0]  rin     [R];
	logic [R-1:0]   tin     [R];
	logic [N-1:0]   vin     [R];
	logic [RW+1:0]  cur     [R];
	logic [RW+1:0]  trial   [R];
	logic [RW-1:0]  rem_nx  [R];
	logic [R-1:0]   root_nx [R];

	// Bring down two radicand bits, try root*4+1
	always_comb begin
		rin[0] = '0;
		tin[0] = '0;
		vin[0] = rad;
		for (int j = 1; j < R; j++) begin
			rin[j] = rem_sx[j-1];
			tin[j] = root_sx[j-1];
			vin[j] = rad_sx[j-1];
		end
		for (int j = 0; j < R; j++) begin
			cur[j] = {rin[j], vin[j][N-1-2*j -: 2]};
			trial[j] = (RW+2)'({tin[j], 2'b01});
			if (cur[j] >= trial[j]) begin
				rem_nx[j] = RW'(cur[j] - trial[j]);
				root_nx[j] = {tin[j][R-2:0], 1'b1};
			end else begin
				rem_nx[j] = cur[j][RW-1:0];
				root_nx[j] = {tin[j][R-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < R; j++) begin
				rem_sx[j] <= rem_nx[j];
				root_sx[j] <= root_nx[j];
				rad_sx[j] <= vin[j];
			end
		end
	end

	assign root = root_sx[R-1];

endmodule

// ===== sv/dual_end_hit_reconstruction.sv =====
// Depth from input transaction to result is set by the 18-step gain multiply
// chain, 36-bit divider and 18-bit root.
// Throughput: one transaction per cycle; a held result stalls the whole pipe.
// Reset: arst_n clears all valid bits and loads register defaults.
// Depends on dhr_pkg, dhr_gain, dhr_div, dhr_sqrt and assert_macros.svh.
`include "assert_macros.svh"
module dual_end_hit_reconstruction (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// time_first, time_second, energy_first, energy_second, zero pad
	input  logic [dhr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// first_is_upstream, both_tdc
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// z_local, z_target, cell_time, corrected_energy, z_sigma, zero pad
	output logic [dhr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// was_clamped
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [dhr_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [dhr_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int L = dhr_pkg::PIPE_LAT;

	// Configuration registers
	logic [dhr_pkg::H_W-1:0]   hfl_q;
	logic [dhr_pkg::H_W-1:0]   hls_q;
	logic [dhr_pkg::CFG_W-1:0] ftt_q;
	logic [dhr_pkg::CFG_W-1:0] iatt_q;
	logic [dhr_pkg::CFG_W-1:0] tofs_q;
	logic [dhr_pkg::CFG_W-1:0] rcoef_q;
	logic [dhr_pkg::CFG_W-1:0] rfall_q;
	logic [dhr_pkg::NUM_W-1:0] num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfl_q   <= dhr_pkg::RST_HALF_FIBER;
			hls_q   <= dhr_pkg::RST_HALF_SPEED;
			ftt_q   <= dhr_pkg::RST_TRANSIT;
			iatt_q  <= dhr_pkg::RST_INV_ATTEN;
			tofs_q  <= dhr_pkg::RST_TARGET_OFS;
			rcoef_q <= dhr_pkg::RST_RES_COEFF;
			rfall_q <= dhr_pkg::RST_RES_FALLBACK;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dhr_pkg::CFG_HALF_FIBER:   hfl_q   <= cfg_wdata[dhr_pkg::H_W-1:0];
				dhr_pkg::CFG_HALF_SPEED:   hls_q   <= cfg_wdata[dhr_pkg::H_W-1:0];
				dhr_pkg::CFG_TRANSIT:      ftt_q   <= cfg_wdata;
				dhr_pkg::CFG_INV_ATTEN:    iatt_q  <= cfg_wdata;
				dhr_pkg::CFG_TARGET_OFS:   tofs_q  <= cfg_wdata;
				dhr_pkg::CFG_RES_COEFF:    rcoef_q <= cfg_wdata;
				dhr_pkg::CFG_RES_FALLBACK: rfall_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Dividend 16 * coeff^2, static between configuration writes
	always_ff @(posedge clk) begin
		num_q <= (dhr_pkg::NUM_W'(rcoef_q) * dhr_pkg::NUM_W'(rcoef_q)) << 4;
	end

	// Global advance: the pipe moves unless the result register is held
	logic          adv;
	logic [L-1:0]  vld_q;

	assign adv = !vld_q[L-1] || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: order hits, time difference and arrival time
	logic signed [dhr_pkg::T_W-1:0] t1, t2, t_up, t_dn;
	logic [dhr_pkg::E_W-1:0]        e1, e2;
	logic signed [dhr_pkg::T_W:0]   dt_c;
	logic signed [dhr_pkg::T_W+2:0] ct_c;
	logic signed [dhr_pkg::T_W:0]   dt_s1;
	logic signed [dhr_pkg::CT_W-1:0] ct_s1;
	logic [dhr_pkg::E_W-1:0]        eup_s1, edn_s1;
	logic                           dual_s1;

	assign t1 = $signed(s_axis_tdata[19:0]);
	assign t2 = $signed(s_axis_tdata[39:20]);
	assign e1 = s_axis_tdata[57:40];
	assign e2 = s_axis_tdata[75:58];
	assign t_up = s_axis_tuser[0] ? t1 : t2;
	assign t_dn = s_axis_tuser[0] ? t2 : t1;
	assign dt_c = (dhr_pkg::T_W+1)'(t_up) - (dhr_pkg::T_W+1)'(t_dn);
	assign ct_c = (dhr_pkg::T_W+3)'(t_up) + (dhr_pkg::T_W+3)'(t_dn)
		- $signed({7'd0, ftt_q}) + 23'sd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s1   <= dt_c;
			ct_s1   <= ct_c[dhr_pkg::CT_W:1];
			eup_s1  <= s_axis_tuser[0] ? e1 : e2;
			edn_s1  <= s_axis_tuser[0] ? e2 : e1;
			dual_s1 <= s_axis_tuser[1];
		end
	end

	// Stage 2: position from time difference, rounded
	logic signed [34:0] zprod;
	logic signed [34:0] zrnd;
	logic signed [26:0] zraw_s2;
	logic signed [dhr_pkg::CT_W-1:0] ct_s2;
	logic [dhr_pkg::E_W-1:0]  eup_s2, edn_s2;
	logic                     dual_s2;

	assign zprod = $signed({1'b0, hls_q}) * dt_s1;
	assign zrnd = zprod + 35'sd128;

	always_ff @(posedge clk) begin
		if (adv) begin
			zraw_s2 <= zrnd[34:8];
			ct_s2   <= ct_s1;
			eup_s2  <= eup_s1;
			edn_s2  <= edn_s1;
			dual_s2 <= dual_s1;
		end
	end

	// Stage 3: clamp, end distances, target position
	logic signed [26:0]             hpos;
	logic signed [dhr_pkg::Z_W-1:0] z_c;
	logic                           clamp_c;
	logic signed [dhr_pkg::Z_W:0]   dup_c, ddn_c;
	dhr_pkg::side_t                 side_s3;
	logic [dhr_pkg::DIST_W-1:0]     dup_s3, ddn_s3;
	logic [dhr_pkg::E_W-1:0]        eup_s3, edn_s3;

	assign hpos = $signed({14'd0, hfl_q});

	always_comb begin
		if (zraw_s2 > hpos) begin
			z_c = $signed({1'b0, hfl_q});
			clamp_c = 1'b1;
		end else if (zraw_s2 < -hpos) begin
			z_c = -$signed({1'b0, hfl_q});
			clamp_c = 1'b1;
		end else begin
			z_c = zraw_s2[dhr_pkg::Z_W-1:0];
			clamp_c = 1'b0;
		end
	end

	assign dup_c = $signed({2'b0, hfl_q}) + (dhr_pkg::Z_W+1)'(z_c);
	assign ddn_c = $signed({2'b0, hfl_q}) - (dhr_pkg::Z_W+1)'(z_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.z_local   <= dhr_pkg::ZL_W'(z_c);
			side_s3.z_target  <= dhr_pkg::ZT_W'(z_c) + dhr_pkg::ZT_W'($signed(tofs_q));
			side_s3.cell_time <= ct_s2;
			side_s3.clamped   <= clamp_c;
			side_s3.dual      <= dual_s2;
			dup_s3 <= dup_c[dhr_pkg::DIST_W-1:0];
			ddn_s3 <= ddn_c[dhr_pkg::DIST_W-1:0];
			eup_s3 <= eup_s2;
			edn_s3 <= edn_s2;
		end
	end

	// Attenuation gains at both ends
	logic [dhr_pkg::GAIN_W-1:0] gup, gdn;

	dhr_gain u_gain_up (
		.clk(clk), .en(adv), .span(dup_s3), .inv_atten(iatt_q), .gain(gup)
	);

	dhr_gain u_gain_dn (
		.clk(clk), .en(adv), .span(ddn_s3), .inv_atten(iatt_q), .gain(gdn)
	);

	// Delay lines alongside the gain, divider and root
	logic [dhr_pkg::E_W-1:0]  eup_sd [dhr_pkg::GAIN_LAT];
	logic [dhr_pkg::E_W-1:0]  edn_sd [dhr_pkg::GAIN_LAT];
	dhr_pkg::side_t           side_sd [dhr_pkg::SIDE_LAT];
	logic [dhr_pkg::EC_W-1:0] ec_sd [dhr_pkg::EC_LAT];
	logic [dhr_pkg::EC_W-1:0] ec_e3;

	always_ff @(posedge clk) begin
		if (adv) begin
			eup_sd[0] <= eup_s3;
			edn_sd[0] <= edn_s3;
			for (int i = 1; i < dhr_pkg::GAIN_LAT; i++) begin
				eup_sd[i] <= eup_sd[i-1];
				edn_sd[i] <= edn_sd[i-1];
			end
			side_sd[0] <= side_s3;
			for (int i = 1; i < dhr_pkg::SIDE_LAT; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
			ec_sd[0] <= ec_e3;
			for (int i = 1; i < dhr_pkg::EC_LAT; i++) begin
				ec_sd[i] <= ec_sd[i-1];
			end
		end
	end

	// Energy: split products, per-end sums, then total with rounding and saturation
	localparam int SP = dhr_pkg::GAIN_SPLIT;
	localparam int PP_W = dhr_pkg::E_W + SP;
	localparam int PR_W = dhr_pkg::E_W + dhr_pkg::GAIN_W;

	logic [PP_W-1:0] plo_up_e1, phi_up_e1, plo_dn_e1, phi_dn_e1;
	logic [PR_W-1:0] prod_up_e2, prod_dn_e2;
	logic [PR_W+1:0] esum;
	logic [PR_W+1:0] ecw;

	assign esum = (PR_W+2)'(prod_up_e2) + (PR_W+2)'(prod_dn_e2) + ((PR_W+2)'(1) << 18);
	assign ecw = esum >> 19;

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_up_e1 <= PP_W'(eup_sd[dhr_pkg::GAIN_LAT-1]) * PP_W'(gup[SP-1:0]);
			phi_up_e1 <= PP_W'(eup_sd[dhr_pkg::GAIN_LAT-1]) * PP_W'(gup[dhr_pkg::GAIN_W-1:SP]);
			plo_dn_e1 <= PP_W'(edn_sd[dhr_pkg::GAIN_LAT-1]) * PP_W'(gdn[SP-1:0]);
			phi_dn_e1 <= PP_W'(edn_sd[dhr_pkg::GAIN_LAT-1]) * PP_W'(gdn[dhr_pkg::GAIN_W-1:SP]);
			prod_up_e2 <= PR_W'(plo_up_e1) + (PR_W'(phi_up_e1) << SP);
			prod_dn_e2 <= PR_W'(plo_dn_e1) + (PR_W'(phi_dn_e1) << SP);
			if (ecw > (PR_W+2)'({dhr_pkg::EC_W{1'b1}})) begin
				ec_e3 <= {dhr_pkg::EC_W{1'b1}};
			end else begin
				ec_e3 <= ecw[dhr_pkg::EC_W-1:0];
			end
		end
	end

	// Resolution: quotient then square root
	logic [dhr_pkg::NUM_W-1:0]  quo;
	logic [dhr_pkg::ROOT_W-1:0] root;

	dhr_div u_div (
		.clk(clk), .en(adv), .num(num_q), .den(ec_e3), .quo(quo)
	);

	dhr_sqrt u_sqrt (
		.clk(clk), .en(adv), .rad(quo), .root(root)
	);

	// Output stage
	dhr_pkg::side_t           side_l;
	logic [dhr_pkg::EC_W-1:0] ec_l;
	logic [dhr_pkg::ROOT_W:0] shalf;
	logic [dhr_pkg::SIG_W-1:0] sigma_c;

	assign side_l = side_sd[dhr_pkg::SIDE_LAT-1];
	assign ec_l = ec_sd[dhr_pkg::EC_LAT-1];
	assign shalf = ((dhr_pkg::ROOT_W+1)'(root) + 1'b1) >> 1;

	always_comb begin
		if (!side_l.dual) begin
			sigma_c = rfall_q;
		end else if (ec_l == '0) begin
			sigma_c = {dhr_pkg::SIG_W{1'b1}};
		end else if (shalf > (dhr_pkg::ROOT_W+1)'({dhr_pkg::SIG_W{1'b1}})) begin
			sigma_c = {dhr_pkg::SIG_W{1'b1}};
		end else begin
			sigma_c = shalf[dhr_pkg::SIG_W-1:0];
		end
	end

	logic signed [dhr_pkg::ZL_W-1:0] zl_q;
	logic signed [dhr_pkg::ZT_W-1:0] zt_q;
	logic signed [dhr_pkg::CT_W-1:0] ct_q;
	logic [dhr_pkg::EC_W-1:0]        ec_q;
	logic [dhr_pkg::SIG_W-1:0]       sigma_q;
	logic                            clamped_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			zl_q      <= side_l.z_local;
			zt_q      <= side_l.z_target;
			ct_q      <= side_l.cell_time;
			ec_q      <= ec_l;
			sigma_q   <= sigma_c;
			clamped_q <= side_l.clamped;
		end
	end

	assign m_axis_tvalid = vld_q[L-1];
	assign m_axis_tdata = {2'b00, sigma_q, ec_q, ct_q, zt_q, zl_q};
	assign m_axis_tuser = clamped_q;

	// Checks
	logic signed [dhr_pkg::ZL_W-1:0] hl;
	logic                            z_at_end;
	logic                            z_in_span;
	logic                            out_held;

	assign hl = $signed({3'b000, hfl_q});
	assign z_at_end = (zl_q == hl) || (zl_q == -hl);
	assign z_in_span = (zl_q <= hl) && (zl_q >= -hl);
	assign out_held = m_axis_tvalid && !m_axis_tready;

	`DHR_ASSERT(a_clamp_at_end, (m_axis_tvalid && m_axis_tuser[0]) |-> z_at_end, "clamp not at end")
	`DHR_ASSERT(a_z_in_range, m_axis_tvalid |-> z_in_span, "position outside half fiber length")
	`DHR_ASSERT(a_stall_from_output, !s_axis_tready |-> out_held, "input stalled without held result")
	`DHR_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

// ===== bench/tb_dual_end_hit_reconstruction.sv =====
// Self-checking bench for dual_end_hit_reconstruction: random and directed hit pairs,
// several register settings, and a scoreboard that recomputes every result.
// Depends on dhr_pkg and the block under test.
module tb_dual_end_hit_reconstruction;

	// Recomputes a reconstructed hit and checks it against the block's output
	class hit_scoreboard;
		logic [15:0] regs [7];
		logic [63:0] exp_q18 [dhr_pkg::EXP_TABLE_DEPTH];
		logic [63:0] e_q18;
		logic [dhr_pkg::OUT_DATA_W-1:0] pending_data [$];
		logic pending_clamp [$];
		int errors;
		int checked;

		function logic [63:0] series(input logic [63:0] num);
			logic [63:0] term;
			logic [63:0] acc;
			term = 64'd1 << 32;
			acc = term;
			for (int j = 1; j < 64 && term != 0; j++) begin
				term = (term * num) / (64'(dhr_pkg::EXP_TABLE_DEPTH) * 64'(j));
				acc += term;
			end
			return (acc + (64'd1 << 13)) >> 14;
		endfunction

		function void init();
			for (int k = 0; k < dhr_pkg::EXP_TABLE_DEPTH; k++)
				exp_q18[k] = series(64'(k));
			e_q18 = series(64'(dhr_pkg::EXP_TABLE_DEPTH));
			regs[0] = 3120; regs[1] = 2144; regs[2] = 372; regs[3] = 126;
			regs[4] = 2352; regs[5] = 282; regs[6] = 480;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(input int idx, input logic [15:0] val);
			if (idx < 7)
				regs[idx] = (idx < 2) ? (val & 16'h1fff) : val;
		endfunction

		// Attenuation gain over a distance in 1/16 cm, Q18, held at 2^43
		function logic [63:0] gain(input logic [63:0] span);
			logic [63:0] a;
			logic [63:0] n;
			logic [63:0] k;
			logic [63:0] g;
			a = span * regs[3];
			n = a >> 20;
			k = ((a & 64'hfffff) * 64'(dhr_pkg::EXP_TABLE_DEPTH)) >> 20;
			g = exp_q18[k];
			for (longint i = 0; i < n; i++) begin
				if (g >= (64'd1 << 43))
					break;
				g = (g * e_q18 + (64'd1 << 17)) >> 18;
			end
			if (g > (64'd1 << 43))
				g = 64'd1 << 43;
			return g;
		endfunction

		function logic [63:0] root(input logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Note an accepted input transaction and queue its expected result
		function void note_hit(input logic [dhr_pkg::IN_DATA_W-1:0] d, input logic [1:0] u);
			longint t1, t2, tu, td, h, z, zt, ct;
			logic [63:0] e1, e2, eu, ed, s, ec, sig, sq;
			logic clamp;
			t1 = longint'($signed(d[19:0]));
			t2 = longint'($signed(d[39:20]));
			e1 = 64'(d[57:40]);
			e2 = 64'(d[75:58]);
			tu = u[0] ? t1 : t2;
			td = u[0] ? t2 : t1;
			eu = u[0] ? e1 : e2;
			ed = u[0] ? e2 : e1;
			h = longint'(regs[0]);
			z = (longint'(regs[1]) * (tu - td) + 128) >>> 8;
			clamp = 0;
			if (z > h) begin
				z = h; clamp = 1;
			end else if (z < -h) begin
				z = -h; clamp = 1;
			end
			zt = z + longint'($signed(regs[4]));
			ct = (tu + td - longint'(regs[2]) + 1) >>> 1;
			s = eu * gain(64'(h + z)) + ed * gain(64'(h - z));
			ec = (s + (64'd1 << 18)) >> 19;
			if (ec > 64'hffffff)
				ec = 64'hffffff;
			if (!u[1]) begin
				sig = 64'(regs[6]);
			end else if (ec == 0) begin
				sig = 64'hffff;
			end else begin
				sq = root((64'd16 * regs[5] * regs[5]) / ec);
				sig = (sq + 1) >> 1;
				if (sig > 64'hffff)
					sig = 64'hffff;
			end
			pending_data.push_back({2'b00, sig[15:0], ec[23:0], ct[20:0], zt[16:0], z[15:0]});
			pending_clamp.push_back(clamp);
		endfunction

		function void cmp(input string name, input logic [31:0] want, input logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted result transaction against the oldest expectation
		function void check_result(input logic [dhr_pkg::OUT_DATA_W-1:0] d, input logic c);
			logic [dhr_pkg::OUT_DATA_W-1:0] w;
			logic wc;
			if (pending_data.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
				return;
			end
			w = pending_data.pop_front();
			wc = pending_clamp.pop_front();
			checked++;
			cmp("z_local", 32'(w[15:0]), 32'(d[15:0]));
			cmp("z_target", 32'(w[32:16]), 32'(d[32:16]));
			cmp("cell_time", 32'(w[53:33]), 32'(d[53:33]));
			cmp("corrected_energy", 32'(w[77:54]), 32'(d[77:54]));
			cmp("z_sigma", 32'(w[93:78]), 32'(d[93:78]));
			cmp("was_clamped", 32'(wc), 32'(c));
			cmp("pad", 32'd0, 32'(d[95:94]));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// time_first, time_second, energy_first, energy_second, pad
	logic [dhr_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;             // first_is_upstream, both_tdc
	logic m_axis_tvalid;
	logic m_axis_tready;
	// z_local, z_target, cell_time, corrected_energy, z_sigma, pad
	logic [dhr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;             // was_clamped
	logic cfg_we;
	logic [dhr_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [dhr_pkg::CFG_W-1:0] cfg_wdata;

	hit_scoreboard sb;
	int send_idle;
	int recv_stall;
	int hits_sent;

	dual_end_hit_reconstruction u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Sample both handshakes at the edge; receiver stalls at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_hit(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser[0]);
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	// Send one hit pair; random idle cycles before it
	task automatic send_hit(input logic [19:0] t1, input logic [19:0] t2,
			input logic [17:0] e1, input logic [17:0] e2, input logic [1:0] u);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'd0, e2, e1, t2, t1};
		s_axis_tuser <= u;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		hits_sent++;
	endtask

	task automatic send_random_hit();
		logic [19:0] t1, t2;
		logic [17:0] e1, e2;
		t1 = 20'($urandom);
		// mostly realistic time differences so the clamp does not always act
		t2 = ($urandom_range(3) != 0) ? t1 + 20'($signed(12'($urandom))) : 20'($urandom);
		case ($urandom_range(5))
			0: e1 = 0;
			1: e1 = 18'($urandom_range(255));
			default: e1 = 18'($urandom);
		endcase
		e2 = ($urandom_range(5) == 0) ? 18'd0 : 18'($urandom);
		send_hit(t1, t2, e1, e2, 2'($urandom));
	endtask

	// Drain: stop sending, wait for every result plus the pipe latency
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_data.size() != 0)
			@(posedge clk);
		repeat (dhr_pkg::PIPE_LAT + 10) @(posedge clk);
	endtask

	// One register write; the caller drops the write enable afterwards
	task automatic write_reg(input logic [dhr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(int'(idx), val);
	endtask

	task automatic write_all(input logic [15:0] v [7]);
		write_reg(dhr_pkg::CFG_HALF_FIBER, v[0]);
		write_reg(dhr_pkg::CFG_HALF_SPEED, v[1]);
		write_reg(dhr_pkg::CFG_TRANSIT, v[2]);
		write_reg(dhr_pkg::CFG_INV_ATTEN, v[3]);
		write_reg(dhr_pkg::CFG_TARGET_OFS, v[4]);
		write_reg(dhr_pkg::CFG_RES_COEFF, v[5]);
		write_reg(dhr_pkg::CFG_RES_FALLBACK, v[6]);
	endtask

	initial begin
		logic [15:0] v [7];
		sb = new();
		sb.init();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_addr = dhr_pkg::CFG_HALF_FIBER;
		cfg_wdata = 0;
		send_idle = 0;
		recv_stall = 0;
		hits_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, both orderings, zero energy, clamps
		send_hit(20'h00000, 20'h00000, 18'd0, 18'd0, 2'b11);
		send_hit(20'h00000, 20'h00000, 18'd0, 18'd0, 2'b10);
		send_hit(20'h7ffff, 20'h80000, 18'h3ffff, 18'h3ffff, 2'b11);
		send_hit(20'h80000, 20'h7ffff, 18'h3ffff, 18'h3ffff, 2'b01);
		send_hit(20'h7ffff, 20'h7ffff, 18'h3ffff, 18'd0, 2'b00);
		send_hit(20'h80000, 20'h80000, 18'd0, 18'h3ffff, 2'b10);
		send_hit(20'h00010, 20'hffff0, 18'd1, 18'd1, 2'b11);
		send_hit(20'hfffff, 20'h00001, 18'd1024, 18'd2048, 2'b01);
		send_hit(20'h00100, 20'h00000, 18'd500, 18'd700, 2'b11);
		send_hit(20'h00000, 20'h00100, 18'd500, 18'd700, 2'b11);
		send_hit(20'h55555, 20'haaaaa, 18'h15555, 18'h2aaaa, 2'b10);
		send_hit(20'haaaaa, 20'h55555, 18'h2aaaa, 18'h15555, 2'b01);
		// pause until all results are in
		drain();

		// Register settings, extremes among them; index 7 must be ignored
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: v = '{16'd3120, 16'd2144, 16'd372, 16'd126, 16'd2352, 16'd282, 16'd480};
				1: v = '{16'h1fff, 16'h1fff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff, 16'hffff};
				2: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0};
				3: v = '{16'd40, 16'd300, 16'd10, 16'd9000, 16'hffff, 16'd1, 16'd5};
				default: for (int i = 0; i < 7; i++) v[i] = 16'($urandom);
			endcase
			if (ph >= 4)
				v[3] = 16'($urandom_range(2000));
			write_all(v);
			cfg_we <= 1;
			cfg_addr <= 3'd7;
			cfg_wdata <= 16'($urandom);
			@(posedge clk);
			cfg_we <= 0;
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 58; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 58; end
				default: begin send_idle = 33; recv_stall = 33; end
			endcase
			for (int i = 0; i < 130; i++)
				send_random_hit();
			drain();
		end

		$display("Covered %0d hit pairs over 8 register settings; %0d results checked.",
			hits_sent, sb.checked);
		if (sb.errors == 0 && sb.pending_data.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end
endmodule
